@@ rtl/msdfr_pkg.sv @@
// shared types, constants and decode functions for the mode s hex frame deframer
`default_nettype none
package msdfr_pkg;

    localparam int LINE_BUF_SIZE = 128;
    localparam int LPOS_W        = $clog2(LINE_BUF_SIZE);
    localparam int WIN_LEN       = 32;
    localparam int HEX_CHARS     = 28;
    localparam int MAX_BYTES     = HEX_CHARS / 2;
    localparam int IDX_W         = 4;
    localparam int CNT_W         = 4;
    localparam int FRAMES_W      = 32;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_TDATA_W   = 48;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic [FRAMES_W-1:0]       frames;
    } t_frame;

    function automatic logic is_kept(input logic [7:0] c);
        return ((c >= CH_SP) && (c <= CH_TILDE)) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [7:0] nibble(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = c - CH_0;
        end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
            v = c - CH_LA + 8'd10;
        end else begin
            v = c - CH_UA + 8'd10;
        end
        return v;
    endfunction

    function automatic logic [7:0] decode_pair(input logic [7:0] h, input logic [7:0] l);
        logic [7:0] hv;
        hv = nibble(h);
        return {hv[3:0], 4'b0000} | nibble(l);
    endfunction

endpackage
`default_nettype wire

@@ rtl/msdfr_front.sv @@
// front end: byte filter, character window, line position, frame detect and hex decode
`default_nettype none
module msdfr_front
    import msdfr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_data,
    input  wire logic         i_full,
    output logic              o_push,
    output t_frame            o_frame
);

    logic [7:0]          r_win [WIN_LEN];
    logic [7:0]          n_win [WIN_LEN];
    logic [LPOS_W-1:0]   r_pos;
    logic [LPOS_W-1:0]   n_pos;
    logic [FRAMES_W-1:0] r_frames;
    logic                acc;
    logic                detect;
    logic [CNT_W-1:0]    cnt;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready && is_kept(i_data);

    always_comb begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            n_win[i] = r_win[i+1];
        end
        n_win[WIN_LEN-1] = i_data;
    end

    assign detect = (r_pos >= LPOS_W'(WIN_LEN - 1)) &&
                    (n_win[0] == CH_STAR) && (n_win[WIN_LEN-3] == CH_SEMI) &&
                    (n_win[WIN_LEN-2] == CH_CR) && (n_win[WIN_LEN-1] == CH_LF);

    always_comb begin
        cnt = CNT_W'(MAX_BYTES);
        for (int k = MAX_BYTES - 1; k >= 0; k--) begin
            if (n_win[1+2*k] == CH_SEMI) begin
                cnt = CNT_W'(k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_BYTES; k++) begin
            o_frame.bytes[k] = decode_pair(n_win[1+2*k], n_win[2+2*k]);
        end
        o_frame.count  = cnt;
        o_frame.frames = r_frames + FRAMES_W'(1);
    end

    assign o_push = acc && detect && (cnt != '0);

    always_comb begin
        if ((i_data == CH_LF) || (r_pos == LPOS_W'(LINE_BUF_SIZE - 1))) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + LPOS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_pos    <= '0;
            r_frames <= '0;
        end else if (acc) begin
            r_win <= n_win;
            r_pos <= n_pos;
            if (detect) begin
                r_frames <= r_frames + FRAMES_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/msdfr_fifo.sv @@
// short queue of decoded frames between front and back
`default_nettype none
module msdfr_fifo
    import msdfr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_frame i_frame,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_frame      o_frame
);

    t_frame                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_frame = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - FIFO_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/msdfr_back.sv @@
// back end: walks a decoded frame and sends one message byte per transaction
`default_nettype none
module msdfr_back
    import msdfr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_frame              i_frame,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [7:0]               o_byte,
    output logic [IDX_W-1:0]         o_idx,
    output logic                     o_last,
    output logic [FRAMES_W-1:0]      o_frames
);

    t_frame           r_cur;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_last;
    logic [FRAMES_W-1:0] r_out_frames;
    logic             emit;
    logic             at_end;

    assign emit   = r_busy && (!r_out_valid || i_ready);
    assign at_end = (r_idx == (r_cur.count - CNT_W'(1)));
    assign o_pop  = i_valid && (!r_busy || (emit && at_end));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_frame;
        end
        if (emit) begin
            r_out_byte   <= r_cur.bytes[r_idx];
            r_out_idx    <= r_idx;
            r_out_last   <= at_end;
            r_out_frames <= r_cur.frames;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (at_end) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_idx    = r_out_idx;
    assign o_last   = r_out_last;
    assign o_frames = r_out_frames;

endmodule
`default_nettype wire

@@ rtl/mode_s_hex_frame_deframer.sv @@
// top level of the mode s raw hex frame deframer
// Takes one received character per transaction and can accept one every cycle; bytes
// outside printable ascii, cr and lf are dropped. A frame line of the form '*', 28 hex
// characters, ';', cr, lf is decoded into up to 14 message bytes, stopping early at a ';'
// in a high-nibble place. Decoded frames wait in a two-frame queue and leave one byte per
// cycle on the output while m_axis_tready is high; input stalls whenever both queue slots
// are taken, whatever the next character is.
`default_nettype none
module mode_s_hex_frame_deframer
    import msdfr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // rx_byte[7:0]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // msg_byte[7:0], byte_index[11:8], frames_seen[43:12], zero[47:44]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast
);

    logic                push;
    t_frame              push_frame;
    logic                full;
    logic                pop;
    logic                q_valid;
    t_frame              q_frame;
    logic [7:0]          out_byte;
    logic [IDX_W-1:0]    out_idx;
    logic [FRAMES_W-1:0] out_frames;

    msdfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_full  (full),
        .o_push  (push),
        .o_frame (push_frame)
    );

    msdfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_frame (q_frame)
    );

    msdfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_frame  (q_frame),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (out_byte),
        .o_idx    (out_idx),
        .o_last   (m_axis_tlast),
        .o_frames (out_frames)
    );

    assign m_axis_tdata = {4'b0000, out_frames, out_idx, out_byte};

endmodule
`default_nettype wire
